@@ sv/adh_pkg.sv @@
package adh_pkg;

	localparam int COORD_W = 24;
	localparam int FRAME_W = 24;
	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int BIN_COORD_W = 23;

	localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

	localparam logic [1:0] REQ_ATOM = 2'd0;
	localparam logic [1:0] REQ_FRAME = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_COUNTED = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;
	localparam logic [1:0] ST_BAD_READ = 2'd3;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_AXIS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPECIES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LAST = 3'd6;

	localparam logic [1:0] RST_AXIS = AXIS_Z;
	localparam logic [7:0] RST_SPECIES = 8'd0;
	localparam logic [15:0] RST_BIN_WIDTH = 16'd256;
	localparam logic [10:0] RST_NUM_BINS = 11'd1024;
	localparam logic [FRAME_W-1:0] RST_FIRST = 24'd1;
	localparam logic [15:0] RST_STRIDE = 16'd1;
	localparam logic [FRAME_W-1:0] RST_LAST = 24'hFF_FFFF;

	typedef struct packed {
		logic [1:0] req_type;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [7:0] species;
		logic [9:0] read_bin;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [25:0] bin_center;
		logic [31:0] avg_count;
		logic [FRAME_W-1:0] frames_counted;
	} rsp_t;

endpackage

@@ sv/adh_ram.sv @@
module adh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/adh_divider.sv @@
module adh_divider #(
	parameter int DW = 40,
	parameter int VW = 24
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [$clog2(DW+1)-1:0] iters,
	input logic [DW-1:0] dividend,
	input logic [VW-1:0] divisor,
	output logic done,
	output logic [DW-1:0] quotient
);

	localparam int CNTW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [DW-1:0] quo_q;
	logic [CNTW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [VW:0] shifted;
	logic [VW+1:0] diff;
	logic fits;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign diff = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits = !diff[VW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			dvs_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= '0;
				dvs_q <= divisor;
				quo_q <= dividend;
				cnt_q <= iters;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? diff[VW-1:0] : shifted[VW-1:0];
				quo_q <= {quo_q[DW-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

@@ sv/axis_density_histogram.sv @@
// frame and bad-read words go straight to the result; atom words run a 23-step
// coordinate divide plus bin read-modify-write; good reads do one bin read plus a
// COUNT_WIDTH+8 step average divide when any frames have been selected
// one word in flight at a time: req_stall stays high until its result is registered
// reset clears counters and registers, then sweeps the whole bin memory to zero
// while req_stall stays high; config writes are taken during the sweep
module axis_density_histogram #(
	parameter int MAX_BINS = 1024,
	parameter int COUNT_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input adh_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output adh_pkg::rsp_t rsp,
	input logic cfg_we,
	input logic [adh_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [adh_pkg::CFG_W-1:0] cfg_data
);

	import adh_pkg::*;

	localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int AVG_DW = COUNT_WIDTH + 8;
	localparam int DW = (AVG_DW > BIN_COORD_W) ? AVG_DW : BIN_COORD_W;
	localparam int CNTW = $clog2(DW + 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV_ATOM,
		S_INC,
		S_RD_WAIT,
		S_DIV_AVG,
		S_DONE
	} state_t;

	state_t state_q;

	logic [1:0] axis_q;
	logic [7:0] species_q;
	logic [15:0] bin_width_q;
	logic [10:0] num_bins_q;
	logic [FRAME_W-1:0] first_q;
	logic [15:0] stride_q;
	logic [FRAME_W-1:0] last_q;

	logic [FRAME_W-1:0] frame_num_q;
	logic [FRAME_W-1:0] sel_frames_q;
	logic [15:0] phase_q;
	logic [BIN_W-1:0] clr_addr_q;
	logic [BIN_W-1:0] idx_q;
	logic [1:0] res_status_q;
	logic [25:0] res_center_q;
	logic [31:0] res_avg_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic req_acc;
	logic rsp_free;
	logic [FRAME_W:0] cur_frame;
	logic frame_sel;
	logic axis_ok;
	logic matched;
	logic signed [COORD_W-1:0] coord;
	logic atom_drop;
	logic [16:0] phase_inc;
	logic [16:0] rb_ext;
	logic [BIN_W-1:0] rb_idx;
	logic rb_bad;
	logic [26:0] center_prod;
	logic [BIN_COORD_W-1:0] atom_bin;
	logic atom_oor;
	logic [63:0] quot_ext;

	logic div_start;
	logic [CNTW-1:0] div_iters;
	logic [DW-1:0] div_dividend;
	logic [FRAME_W-1:0] div_divisor;
	logic div_done;
	logic [DW-1:0] div_quot;

	logic ram_we;
	logic [BIN_W-1:0] ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic [BIN_W-1:0] ram_raddr;
	logic [COUNT_WIDTH-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= RST_AXIS;
			species_q <= RST_SPECIES;
			bin_width_q <= RST_BIN_WIDTH;
			num_bins_q <= RST_NUM_BINS;
			first_q <= RST_FIRST;
			stride_q <= RST_STRIDE;
			last_q <= RST_LAST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AXIS: axis_q <= cfg_data[1:0];
				REG_SPECIES: species_q <= cfg_data[7:0];
				REG_BIN_WIDTH: bin_width_q <= cfg_data[15:0];
				REG_NUM_BINS: num_bins_q <= cfg_data[10:0];
				REG_FIRST: first_q <= cfg_data;
				REG_STRIDE: stride_q <= cfg_data[15:0];
				REG_LAST: last_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign req_acc = req_valid && !req_stall;
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	assign cur_frame = {1'b0, frame_num_q} + 1'b1;
	assign frame_sel = (cur_frame >= {1'b0, first_q}) && (cur_frame <= {1'b0, last_q})
		&& (phase_q == '0);
	assign axis_ok = (axis_q == AXIS_X) || (axis_q == AXIS_Y) || (axis_q == AXIS_Z);
	assign matched = axis_ok && (req.species == species_q) && frame_sel;
	assign phase_inc = {1'b0, phase_q} + 1'b1;

	always_comb begin
		unique case (axis_q)
			AXIS_X: coord = req.pos_x;
			AXIS_Y: coord = req.pos_y;
			default: coord = req.pos_z;
		endcase
	end

	assign atom_drop = coord[COORD_W-1] || (bin_width_q == '0);

	assign rb_ext = 17'(req.read_bin);
	assign rb_idx = rb_ext[BIN_W-1:0];
	assign rb_bad = (11'(req.read_bin) >= num_bins_q) || (32'(req.read_bin) >= 32'(MAX_BINS));
	assign center_prod = 27'({req.read_bin, 1'b1}) * 27'(bin_width_q);

	assign atom_bin = div_quot[BIN_COORD_W-1:0];
	assign atom_oor = (11'(atom_bin) >= num_bins_q) || (|atom_bin[BIN_COORD_W-1:11])
		|| (32'(atom_bin) >= 32'(MAX_BINS));
	assign quot_ext = 64'(div_quot);

	// divider feed: coordinate over bin width, or scaled count over selected frames
	always_comb begin
		div_start = 1'b0;
		div_iters = CNTW'(BIN_COORD_W);
		div_dividend = DW'(coord[BIN_COORD_W-1:0]) << (DW - BIN_COORD_W);
		div_divisor = FRAME_W'(bin_width_q);
		if (state_q == S_IDLE) begin
			div_start = req_acc && (req.req_type == REQ_ATOM) && matched && !atom_drop;
		end else if (state_q == S_RD_WAIT) begin
			div_start = (sel_frames_q != '0);
			div_iters = CNTW'(AVG_DW);
			div_dividend = DW'({ram_rdata, 8'h00}) << (DW - AVG_DW);
			div_divisor = sel_frames_q;
		end
	end

	adh_divider #(
		.DW(DW),
		.VW(FRAME_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.iters(div_iters),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_quot)
	);

	assign ram_we = (state_q == S_CLEAR) || (state_q == S_INC);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_addr_q : idx_q;
	assign ram_wdata = (state_q == S_CLEAR) ? '0
		: ((ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1);
	assign ram_raddr = (state_q == S_IDLE) ? rb_idx : atom_bin[BIN_W-1:0];

	adh_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(MAX_BINS)
	) u_bins (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_addr_q <= '0;
			idx_q <= '0;
			frame_num_q <= '0;
			sel_frames_q <= '0;
			phase_q <= '0;
			res_status_q <= ST_DONE;
			res_center_q <= '0;
			res_avg_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (32'(clr_addr_q) == 32'(MAX_BINS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						res_status_q <= ST_DONE;
						res_center_q <= '0;
						res_avg_q <= '0;
						state_q <= S_DONE;
						unique case (req.req_type)
							REQ_ATOM: begin
								if (matched) begin
									if (atom_drop) begin
										res_status_q <= ST_DROPPED;
									end else begin
										state_q <= S_DIV_ATOM;
									end
								end
							end
							REQ_FRAME: begin
								if (axis_ok && frame_sel && sel_frames_q != FRAME_MAX) begin
									sel_frames_q <= sel_frames_q + 1'b1;
								end
								if (cur_frame >= {1'b0, first_q}) begin
									phase_q <= (phase_inc >= {1'b0, stride_q}) ? '0
										: phase_inc[15:0];
								end else begin
									phase_q <= '0;
								end
								if (frame_num_q != FRAME_MAX) begin
									frame_num_q <= frame_num_q + 1'b1;
								end
							end
							REQ_READ: begin
								if (rb_bad) begin
									res_status_q <= ST_BAD_READ;
								end else begin
									res_center_q <= center_prod[26:1];
									state_q <= S_RD_WAIT;
								end
							end
							default: ;
						endcase
					end
				end
				S_DIV_ATOM: begin
					if (div_done) begin
						if (atom_oor) begin
							res_status_q <= ST_DROPPED;
							state_q <= S_DONE;
						end else begin
							idx_q <= atom_bin[BIN_W-1:0];
							state_q <= S_INC;
						end
					end
				end
				S_INC: begin
					res_status_q <= ST_COUNTED;
					state_q <= S_DONE;
				end
				S_RD_WAIT: begin
					state_q <= (sel_frames_q == '0) ? S_DONE : S_DIV_AVG;
				end
				S_DIV_AVG: begin
					if (div_done) begin
						res_avg_q <= (|quot_ext[63:32]) ? 32'hFFFF_FFFF : quot_ext[31:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_q.status <= res_status_q;
						rsp_q.bin_center <= res_center_q;
						rsp_q.avg_count <= res_avg_q;
						rsp_q.frames_counted <= sel_frames_q;
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_sel_le_frames: assert property (@(posedge clk) disable iff (!arst_n)
		sel_frames_q <= frame_num_q)
		else $error("selected frame count above closed frame count");

	a_ram_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_INC))
		else $error("bin memory written outside clear or increment");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV_ATOM || state_q == S_DIV_AVG))
		else $error("divider finished with no divide pending");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rsp_valid_q && rsp_stall) |=> state_q == S_DONE)
		else $error("result left while output word still stalled");

	a_start_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (state_q == S_IDLE || state_q == S_RD_WAIT))
		else $error("divider started from wrong state");

endmodule
